// ----- hdl/hioe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hioe_pkg: shared types and constants for the hard-iron offset estimator
// Holds payload structs, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package hioe_pkg;

  localparam int EXTREME_COUNT_DEF = 10;
  localparam int SAMPLE_WIDTH_DEF  = 16;

  // Payload widths follow the sample width
  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int OW = SW + 1;

  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef struct packed {
    logic          command;
    logic [SW-1:0] sample_x;
    logic [SW-1:0] sample_y;
    logic [SW-1:0] sample_z;
  } in_item_t;

  typedef struct packed {
    logic [OW-1:0] offset_x_doubled;
    logic [OW-1:0] offset_y_doubled;
    logic [OW-1:0] offset_z_doubled;
    logic          enough_samples;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture sample, clear walk
    logic ins_step; // one insertion step at walk position
    logic sum_clr;  // clear accumulators
    logic sum_step; // accumulate one entry
    logic finish;   // form result into output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;     // sample count saturated
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- hdl/hioe_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hioe_ctrl: sequencer for the hard-iron offset estimator
// Walks K insertion steps per sample, or K summing steps per compute once full.
// ----------------------------------------------------------------------------
module hioe_ctrl import hioe_pkg::*; #(
  parameter int EXTREME_COUNT = EXTREME_COUNT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     in_cmd,
  output logic          out_valid,
  input  wire logic     out_stall,
  output dp_cmd_t       cmd,
  input  dp_stat_t      stat,
  output logic [$clog2(EXTREME_COUNT+1)-1:0] pos
);

  localparam int CW = $clog2(EXTREME_COUNT + 1);
  localparam logic [CW-1:0] LAST = CW'(EXTREME_COUNT - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          oval_r, oval_nxt;
  logic          acc;

  assign in_stall  = (state_r != ST_IDLE) || oval_r;
  assign acc       = in_valid && !in_stall;
  assign out_valid = oval_r;
  assign pos       = pos_r;

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    oval_nxt  = oval_r && out_stall;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          pos_nxt = '0;
          if (in_cmd == CMD_ADD) begin
            cmd.load  = 1'b1;
            state_nxt = ST_INS;
          end else if (stat.full) begin
            cmd.sum_clr = 1'b1;
            state_nxt   = ST_SUM;
          end else begin
            cmd.finish = 1'b1;
            oval_nxt   = 1'b1;
          end
        end
      end
      ST_INS: begin
        cmd.ins_step = 1'b1;
        pos_nxt      = pos_r + 1'b1;
        if (pos_r == LAST) state_nxt = ST_IDLE;
      end
      ST_SUM: begin
        if (pos_r == CW'(EXTREME_COUNT)) begin
          // sums complete; averages register on this edge
          state_nxt = ST_DIV;
        end else begin
          cmd.sum_step = 1'b1;
          pos_nxt      = pos_r + 1'b1;
        end
      end
      ST_DIV: begin
        cmd.finish = 1'b1;
        oval_nxt   = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hioe_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hioe_dp: extreme lists, insertion walk and averaging datapath
// Each insertion step fixes one list slot; sums run one entry per cycle.
// ----------------------------------------------------------------------------
module hioe_dp import hioe_pkg::*; #(
  parameter int EXTREME_COUNT = EXTREME_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  input  wire logic [$clog2(EXTREME_COUNT+1)-1:0] pos,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  localparam int SAMPLE_WIDTH = SW;
  localparam int K  = EXTREME_COUNT;
  localparam int CW = $clog2(K + 1);
  localparam int IW = (K > 1) ? $clog2(K) : 1;
  localparam int AW = SAMPLE_WIDTH + $clog2(K + 1) + 1;
  localparam int NL = 6;  // lo x, hi x, lo y, hi y, lo z, hi z

  // reciprocal of K for an exact truncating divide of |sum|
  localparam int L  = $clog2(K);
  localparam int RS = AW + L;
  localparam int MW = AW + 1;
  localparam int PW = RS + AW;
  localparam logic [MW-1:0] RM = MW'(((64'd1 << RS) + 64'(K) - 64'd1) / 64'(K));

  logic signed [SAMPLE_WIDTH-1:0] list_r [NL][K];
  logic signed [AW-1:0]           sum_r [NL];
  logic signed [AW-1:0]           avg_r [NL];
  logic        [CW-1:0]           cnt_r;
  logic                           grow_r;   // list not yet full at load
  out_item_t                      res_r;
  logic        [IW-1:0]           idx;

  assign idx       = pos[IW-1:0];
  assign stat.full = (cnt_r == CW'(K));
  assign out_data  = res_r;

  // sample count, saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load && cnt_r != CW'(K)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Insertion walk from slot 0 upward: a slot takes the new value where it beats
  // the held one, and the displaced value travels on as the carried value.
  // The empty slot (index equal to the count at load) takes the carried value as is.
  logic signed [SAMPLE_WIDTH-1:0] carry_r [NL];
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      carry_r[0] <= SAMPLE_WIDTH'(signed'(in_data.sample_x));
      carry_r[1] <= SAMPLE_WIDTH'(signed'(in_data.sample_x));
      carry_r[2] <= SAMPLE_WIDTH'(signed'(in_data.sample_y));
      carry_r[3] <= SAMPLE_WIDTH'(signed'(in_data.sample_y));
      carry_r[4] <= SAMPLE_WIDTH'(signed'(in_data.sample_z));
      carry_r[5] <= SAMPLE_WIDTH'(signed'(in_data.sample_z));
      grow_r     <= (cnt_r != CW'(K));
    end else if (cmd.ins_step) begin
      for (int l = 0; l < NL; l++) begin
        logic signed [SAMPLE_WIDTH-1:0] held;
        logic                           empty, better;
        held   = list_r[l][idx];
        empty  = grow_r && (pos == cnt_r - 1'b1);
        better = l[0] ? (carry_r[l] > held) : (carry_r[l] < held);
        if (empty) begin
          list_r[l][idx] <= carry_r[l];
        end else if (better) begin
          list_r[l][idx] <= carry_r[l];
          carry_r[l]     <= held;
        end
      end
    end
  end

  // accumulation and result
  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      for (int l = 0; l < NL; l++) sum_r[l] <= '0;
    end else if (cmd.sum_step) begin
      for (int l = 0; l < NL; l++)
        sum_r[l] <= sum_r[l] + AW'(list_r[l][idx]);
    end
  end

  // divide by K, truncating toward zero: scale the magnitude, restore the sign
  function automatic logic signed [AW-1:0] div_k(input logic signed [AW-1:0] s);
    logic [AW-1:0] mag;
    logic [PW-1:0] prod;
    logic [AW-1:0] q;
    mag   = s[AW-1] ? (~s + AW'(1)) : s;
    prod  = PW'(mag) * PW'(RM);
    q     = prod[RS +: AW];
    div_k = s[AW-1] ? (~q + AW'(1)) : q;
  endfunction

  // registered group averages
  always_ff @(posedge clk) begin
    for (int l = 0; l < NL; l++) avg_r[l] <= div_k(sum_r[l]);
  end

  logic signed [AW-1:0] dx, dy, dz;
  always_comb begin
    dx = avg_r[0] + avg_r[1];
    dy = avg_r[2] + avg_r[3];
    dz = avg_r[4] + avg_r[5];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r.enough_samples   <= stat.full;
      res_r.offset_x_doubled <= stat.full ? OW'(dx) : '0;
      res_r.offset_y_doubled <= stat.full ? OW'(dy) : '0;
      res_r.offset_z_doubled <= stat.full ? OW'(dz) : '0;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hard_iron_offset_estimator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hard_iron_offset_estimator_unit: magnetometer hard-iron calibration
// Keeps the K smallest and largest samples per axis and reports offsets x2.
// ----------------------------------------------------------------------------
// An add transaction loads the sample, then takes one insertion step per list
// slot, all six lists in parallel; a compute transaction runs K summing steps
// over the stored lists, a divide step and result when K samples have been
// seen, else it forms a result with zero offsets directly. One transaction is
// in flight at a time; input stalls while a result waits on the output register.
// ----------------------------------------------------------------------------
module hard_iron_offset_estimator_unit import hioe_pkg::*; #(
  parameter int EXTREME_COUNT = EXTREME_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [$clog2(EXTREME_COUNT+1)-1:0] pos;

  hioe_ctrl #(.EXTREME_COUNT(EXTREME_COUNT)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd(in_data.command),
    .out_valid, .out_stall, .cmd, .stat, .pos
  );

  hioe_dp #(.EXTREME_COUNT(EXTREME_COUNT)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .pos, .stat, .out_data
  );

endmodule
`default_nettype wire
